>>> rtl/cht_pkg.sv
package cht_pkg;

	localparam int MAX_BUCKETS_DEF = 64;
	localparam int POOL_NODES_DEF  = 256;
	localparam int KEY_BITS_DEF    = 31;

	localparam int              CFG_W         = 7;
	localparam logic [CFG_W-1:0] BUCKETS_RESET = 7'd7;
	localparam int              SLOT_W        = 8;
	localparam int              MODE_W        = 2;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
		logic              found;
	} result_t;

endpackage

>>> rtl/cht_front.sv
module cht_front #(
	parameter int MAX_BUCKETS = 64,
	parameter int KEY_BITS    = 31,
	parameter int BW          = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cht_pkg::CFG_W-1:0]  bucket_count,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cht_pkg::MODE_W-1:0] in_mode,
	input  logic [KEY_BITS-1:0]        in_key,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cht_pkg::MODE_W-1:0] out_mode,
	output logic [KEY_BITS-1:0]        out_key,
	output logic [BW-1:0]              out_bucket
);
	import cht_pkg::*;

	localparam int CW   = $clog2(MAX_BUCKETS + 1);
	localparam int EW   = (CW > CFG_W) ? CW : CFG_W;
	localparam int CNTW = $clog2(KEY_BITS + 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t             state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] sh_q;
	logic [EW-1:0]       rem_q;
	logic [CNTW-1:0]     cnt_q;
	logic [EW-1:0]       cnt_ext;
	logic [EW-1:0]       eff;
	logic [EW:0]         trial;
	logic [EW-1:0]       rem_nx;

	// Clamp the bucket count into 1..MAX_BUCKETS.
	always_comb begin
		cnt_ext = EW'(bucket_count);
		if (cnt_ext == '0) begin
			eff = EW'(1);
		end else if (cnt_ext > EW'(MAX_BUCKETS)) begin
			eff = EW'(MAX_BUCKETS);
		end else begin
			eff = cnt_ext;
		end
		// One restoring step of the remainder, most significant key bit first.
		trial = {rem_q, sh_q[KEY_BITS-1]};
		if (trial >= {1'b0, eff}) begin
			rem_nx = EW'(trial - {1'b0, eff});
		end else begin
			rem_nx = trial[EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_DIV;
				F_DIV:  if (cnt_q == '0) state_q <= F_PUSH;
				F_PUSH: if (out_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			mode_q <= in_mode;
			key_q  <= in_key;
			sh_q   <= in_key;
			rem_q  <= '0;
			cnt_q  <= CNTW'(KEY_BITS - 1);
		end else if (state_q == F_DIV) begin
			rem_q <= rem_nx;
			sh_q  <= sh_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign in_ready   = (state_q == F_IDLE);
	assign out_valid  = (state_q == F_PUSH);
	assign out_mode   = mode_q;
	assign out_key    = key_q;
	assign out_bucket = rem_q[BW-1:0];

endmodule

>>> rtl/cht_fifo.sv
module cht_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	output logic             nonempty,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("request queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("request queue count out of range");
`endif

endmodule

>>> rtl/cht_back.sv
module cht_back #(
	parameter int MAX_BUCKETS = 64,
	parameter int POOL_NODES  = 256,
	parameter int KEY_BITS    = 31,
	parameter int BW          = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [cht_pkg::MODE_W-1:0] req_mode,
	input  logic [KEY_BITS-1:0]        req_key,
	input  logic [BW-1:0]              req_bucket,
	output logic                       res_valid,
	input  logic                       res_ready,
	output cht_pkg::result_t           res
);
	import cht_pkg::*;

	localparam int IW  = $clog2(POOL_NODES);
	localparam int NW  = IW + 1;
	localparam int GSW = 4;
	localparam int GS  = 1 << GSW;
	localparam int NG  = (POOL_NODES + GS - 1) / GS;
	localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
	localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_FREE = 6'b000010,
		B_HEAD = 6'b000100,
		B_TAIL = 6'b001000,
		B_WALK = 6'b010000,
		B_RESP = 6'b100000
	} bstate_t;

	logic [KEY_BITS-1:0] key_mem  [POOL_NODES];
	logic [NW-1:0]       link_mem [POOL_NODES];
	logic [NW-1:0]       head_mem [MAX_BUCKETS];
	logic [MAX_BUCKETS-1:0] head_vld_q;
	logic [POOL_NODES-1:0]  used_q;

	bstate_t             state_q;
	mode_t               mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [BW-1:0]       bucket_q;
	logic [IW-1:0]       fresh_q;
	logic [IW-1:0]       cur_q;
	logic [NW-1:0]       prev_q;
	logic [GW-1:0]       grp_q;
	result_t             res_q;

	logic [KEY_BITS-1:0] key_rd_q;
	logic [NW-1:0]       link_rd_q;
	logic [NW-1:0]       head_rd_q;

	logic [NG*GS-1:0] used_pad;
	logic [GS-1:0]    grp_bits;
	logic             grp_hit;
	logic [GSW-1:0]   grp_pe;
	logic [IW-1:0]    fresh_idx;
	logic [NW-1:0]    head_val;

	logic            node_re;
	logic [IW-1:0]   node_ra;
	logic            key_we;
	logic            link_we;
	logic [IW-1:0]   link_wa;
	logic [NW-1:0]   link_wd;
	logic            head_we;
	logic [NW-1:0]   head_wd;
	logic            used_set;
	logic            used_clr;
	bstate_t         state_nx;
	result_t         res_nx;
	logic            res_load;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
		logic [IW+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, idx};
		return ext[SLOT_W-1:0];
	endfunction

	always_comb begin
		used_pad = '1;
		used_pad[POOL_NODES-1:0] = used_q;
		grp_bits = used_pad[{grp_q, {GSW{1'b0}}} +: GS];
		grp_hit  = ~&grp_bits;
		grp_pe   = '0;
		for (int i = GS - 1; i >= 0; i--) begin
			if (!grp_bits[i]) grp_pe = GSW'(i);
		end
		fresh_idx = IW'({grp_q, grp_pe});
		head_val  = head_vld_q[bucket_q] ? head_rd_q : NIL;
	end

	always_comb begin
		state_nx = state_q;
		node_re  = 1'b0;
		node_ra  = cur_q;
		key_we   = 1'b0;
		link_we  = 1'b0;
		link_wa  = fresh_q;
		link_wd  = NIL;
		head_we  = 1'b0;
		head_wd  = NIL;
		used_set = 1'b0;
		used_clr = 1'b0;
		res_load = 1'b0;
		res_nx   = '{slot: '0, status: ST_OK, found: 1'b0};
		unique case (state_q)
			B_IDLE: begin
				if (req_valid) begin
					unique case (mode_t'(req_mode))
						MODE_NONE: begin
							res_load = 1'b1;
							state_nx = B_RESP;
						end
						MODE_INSERT: state_nx = B_FREE;
						default:     state_nx = B_HEAD;
					endcase
				end
			end
			B_FREE: begin
				if (grp_hit) begin
					key_we   = 1'b1;
					link_we  = 1'b1;
					link_wa  = fresh_idx;
					used_set = 1'b1;
					state_nx = B_HEAD;
				end else if (grp_q == GW'(NG - 1)) begin
					res_load = 1'b1;
					res_nx   = '{slot: '0, status: ST_FULL, found: 1'b0};
					state_nx = B_RESP;
				end
			end
			B_HEAD: begin
				if (head_val >= NIL) begin
					res_load = 1'b1;
					if (mode_q == MODE_INSERT) begin
						head_we  = 1'b1;
						head_wd  = NW'(fresh_q);
						res_nx   = '{slot: to_slot(fresh_q), status: ST_OK, found: 1'b1};
					end else begin
						res_nx   = '{slot: '0, status: ST_ABSENT, found: 1'b0};
					end
					state_nx = B_RESP;
				end else begin
					node_re  = 1'b1;
					node_ra  = head_val[IW-1:0];
					state_nx = (mode_q == MODE_INSERT) ? B_TAIL : B_WALK;
				end
			end
			B_TAIL: begin
				if (link_rd_q >= NIL) begin
					link_we  = 1'b1;
					link_wa  = cur_q;
					link_wd  = NW'(fresh_q);
					res_load = 1'b1;
					res_nx   = '{slot: to_slot(fresh_q), status: ST_OK, found: 1'b1};
					state_nx = B_RESP;
				end else begin
					node_re = 1'b1;
					node_ra = link_rd_q[IW-1:0];
				end
			end
			B_WALK: begin
				if (key_rd_q == key_q) begin
					res_load = 1'b1;
					res_nx   = '{slot: to_slot(cur_q), status: ST_OK, found: 1'b1};
					if (mode_q == MODE_REMOVE) begin
						used_clr = 1'b1;
						if (prev_q >= NIL) begin
							head_we = 1'b1;
							head_wd = link_rd_q;
						end else begin
							link_we = 1'b1;
							link_wa = prev_q[IW-1:0];
							link_wd = link_rd_q;
						end
					end
					state_nx = B_RESP;
				end else if (link_rd_q >= NIL) begin
					res_load = 1'b1;
					res_nx   = '{slot: '0, status: ST_ABSENT, found: 1'b0};
					state_nx = B_RESP;
				end else begin
					node_re = 1'b1;
					node_ra = link_rd_q[IW-1:0];
				end
			end
			B_RESP: begin
				if (res_ready) state_nx = B_IDLE;
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			head_vld_q <= '0;
			used_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (head_we) head_vld_q[bucket_q] <= 1'b1;
			if (used_set) used_q[fresh_idx] <= 1'b1;
			if (used_clr) used_q[cur_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && req_valid) begin
			mode_q    <= mode_t'(req_mode);
			key_q     <= req_key;
			bucket_q  <= req_bucket;
			grp_q     <= '0;
			prev_q    <= NIL;
			head_rd_q <= head_mem[req_bucket];
		end else if (state_q == B_FREE && !grp_hit) begin
			grp_q <= grp_q + 1'b1;
		end
		if (used_set) fresh_q <= fresh_idx;
		if (node_re) begin
			if (state_q == B_WALK) prev_q <= NW'(cur_q);
			cur_q     <= node_ra;
			key_rd_q  <= key_mem[node_ra];
			link_rd_q <= link_mem[node_ra];
		end
		if (res_load) res_q <= res_nx;
		if (key_we) key_mem[fresh_idx] <= key_q;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (head_we) head_mem[bucket_q] <= head_wd;
	end

	assign req_ready = (state_q == B_IDLE);
	assign res_valid = (state_q == B_RESP);
	assign res       = res_q;

`ifndef SYNTHESIS
	a_alloc_free_node: assert property (@(posedge clk) disable iff (!arst_n)
		used_set |-> !used_q[fresh_idx])
		else $error("allocated a node that is already in use");
	a_remove_used_node: assert property (@(posedge clk) disable iff (!arst_n)
		used_clr |-> used_q[cur_q])
		else $error("freed a node that is not in use");
	a_insert_marked: assert property (@(posedge clk) disable iff (!arst_n)
		used_set |=> used_q[$past(fresh_idx)])
		else $error("new node not marked in use");
`endif

endmodule

>>> rtl/chained_hash_table.sv
// Flow: a request is accepted, its bucket is worked out by a bit-serial remainder in the front end
// and it passes the request queue to the back end; the unused mode is answered without touching
// the table, the other modes walk the chain node by node, and insert first scans groups of 16 pool nodes.
// Throughput is set by the bit-serial remainder divider in the front end while chains stay short;
// the front end takes no new request until the current one has been handed to the queue.
// Reset: arst_n clears all chains, frees every pool node and sets bucket_count to 7.
module chained_hash_table #(
	parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
	parameter int POOL_NODES  = cht_pkg::POOL_NODES_DEF,
	parameter int KEY_BITS    = cht_pkg::KEY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Bucket count register write.
	input  logic                      cfg_we,
	input  logic [cht_pkg::CFG_W-1:0] cfg_wdata,
	// Request stream.
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// tdata fields from bit 0 up: mode (2), key (KEY_BITS), zero fill to whole bytes.
	input  logic [((cht_pkg::MODE_W+KEY_BITS+7)/8)*8-1:0] s_axis_tdata,
	// Result stream.
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// tdata fields from bit 0 up: found (1), status (2), slot (8), zero fill to 16 bits.
	output logic [15:0]               m_axis_tdata
);
	import cht_pkg::*;

	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int QW = MODE_W + KEY_BITS + BW;
	localparam int RW = $bits(result_t);

	// The bucket count is to be rewritten only while the table is idle (the block
	// does not enforce this), so the front end reads it directly.
	logic [CFG_W-1:0] bucket_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKETS_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	// Front end: takes a request and works out its bucket one key bit per cycle.
	logic                f_valid;
	logic                f_ready;
	logic [MODE_W-1:0]   f_mode;
	logic [KEY_BITS-1:0] f_key;
	logic [BW-1:0]       f_bucket;

	cht_front #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.KEY_BITS    (KEY_BITS),
		.BW          (BW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bucket_count_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_mode      (s_axis_tdata[MODE_W-1:0]),
		.in_key       (s_axis_tdata[MODE_W +: KEY_BITS]),
		.out_valid    (f_valid),
		.out_ready    (f_ready),
		.out_mode     (f_mode),
		.out_key      (f_key),
		.out_bucket   (f_bucket)
	);

	// A two-entry queue lets the divider start on the next request while the
	// back end is still walking a chain.
	logic          q_full;
	logic          q_nonempty;
	logic          q_pop;
	logic [QW-1:0] q_rdata;
	logic          b_ready;

	assign f_ready = !q_full;
	assign q_pop   = q_nonempty && b_ready;

	cht_fifo #(
		.WIDTH (QW),
		.DEPTH (2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid && !q_full),
		.full     (q_full),
		.wdata    ({f_bucket, f_key, f_mode}),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.rdata    (q_rdata)
	);

	// Back end: owns the bucket heads and the node pool and carries out the request.
	logic    r_valid;
	logic    r_ready;
	result_t r_res;

	cht_back #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.POOL_NODES  (POOL_NODES),
		.KEY_BITS    (KEY_BITS),
		.BW          (BW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (q_nonempty),
		.req_ready  (b_ready),
		.req_mode   (q_rdata[MODE_W-1:0]),
		.req_key    (q_rdata[MODE_W +: KEY_BITS]),
		.req_bucket (q_rdata[MODE_W+KEY_BITS +: BW]),
		.res_valid  (r_valid),
		.res_ready  (r_ready),
		.res        (r_res)
	);

	// Output register: the back end hands its result over and can take the
	// next request while the result waits here for the consumer.
	logic    out_vld_q;
	result_t out_q;

	assign r_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (r_ready) begin
			out_vld_q <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (r_ready && r_valid) begin
			out_q <= r_res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(16 - RW)'(0), out_q};

endmodule
